/* rtl/escc_pkg.sv */
// ----------------------------------------------------------------------------
// escc_pkg
// Shared constants and tables for the epoch seconds / calendar converter.
// ----------------------------------------------------------------------------
package escc_pkg;

	localparam int unsigned IN_DATA_W  = 72;
	localparam int unsigned OUT_DATA_W = 80;

	// operation codes carried in tuser
	localparam logic OP_DECODE = 1'b0;
	localparam logic OP_ENCODE = 1'b1;

	// reciprocal multipliers for division by constants
	localparam logic [25:0] RCP_675  = 26'd50903317; // x/675,  x < 2^25, shift 35
	localparam logic [17:0] RCP_365  = 18'd183860;   // x/365,  x < 2^17, shift 26
	localparam logic [17:0] RCP_3600 = 18'd149131;   // x/3600, x < 2^17, shift 29
	localparam logic [12:0] RCP_60   = 13'd4370;     // x/60,   x < 2^12, shift 18
	localparam logic [10:0] RCP_25   = 11'd1311;     // x/25,   x < 2^10, shift 15
	localparam logic [14:0] RCP_7    = 15'd18725;    // x/7,    x < 2^14, shift 17

	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [16:0] EPOCH_DAYS    = 17'd25567;
	localparam logic [11:0] BASE_YEAR     = 12'd1900;
	localparam logic [13:0] WD_BIAS       = 14'd7000;

	// days before the first of a month, month index 0..11
	function automatic logic [8:0] cum_days(input logic [3:0] mi, input logic leap);
		logic [8:0] v;
		unique case (mi)
			4'd0:    v = 9'd0;
			4'd1:    v = 9'd31;
			4'd2:    v = leap ? 9'd60  : 9'd59;
			4'd3:    v = leap ? 9'd91  : 9'd90;
			4'd4:    v = leap ? 9'd121 : 9'd120;
			4'd5:    v = leap ? 9'd152 : 9'd151;
			4'd6:    v = leap ? 9'd182 : 9'd181;
			4'd7:    v = leap ? 9'd213 : 9'd212;
			4'd8:    v = leap ? 9'd244 : 9'd243;
			4'd9:    v = leap ? 9'd274 : 9'd273;
			4'd10:   v = leap ? 9'd305 : 9'd304;
			4'd11:   v = leap ? 9'd335 : 9'd334;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/escc_dec.sv */
// ----------------------------------------------------------------------------
// escc_dec
// Six-stage decode of epoch seconds into year, month, day and time of day.
// ----------------------------------------------------------------------------
module escc_dec (
	input  logic        clk,
	input  logic        adv,
	input  logic [31:0] secs,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  sec
);
	import escc_pkg::*;

	logic [50:0] p1_s1;
	logic [31:0] s_s1;
	logic [16:0] rem_s2, dt_s2;
	logic [34:0] py_s3, ph_s3;
	logic [16:0] rem_s3, dt_s3;
	logic [7:0]  yoff_s4;
	logic [16:0] sa_s4, sb_s4, dt_s4;
	logic [4:0]  hour_s4, hour_s5;
	logic [11:0] r2_s4, r2_s5;
	logic [7:0]  yoff_s5;
	logic [8:0]  doy_s5;
	logic [24:0] pm_s5;

	logic [15:0] q2;
	logic [7:0]  yoff4, ym4;
	logic [4:0]  hour4;
	logic        lt5;
	logic        leap6;
	logic [3:0]  mon6;
	logic [5:0]  min6;

	// stage 1: seconds / 86400 as (s >> 7) / 675
	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s1 <= 51'(secs[31:7]) * 51'(RCP_675);
			s_s1  <= secs;
		end
	end

	// stage 2: day count and seconds of day
	assign q2 = p1_s1[50:35];
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s2 <= 17'(s_s1 - 32'(33'(q2) * 33'(SECS_PER_DAY)));
			dt_s2  <= 17'(q2) + EPOCH_DAYS;
		end
	end

	// stage 3: reciprocal products for year and hour
	always_ff @(posedge clk) begin
		if (adv) begin
			py_s3  <= 35'(dt_s2) * 35'(RCP_365);
			ph_s3  <= 35'(rem_s2) * 35'(RCP_3600);
			rem_s3 <= rem_s2;
			dt_s3  <= dt_s2;
		end
	end

	// stage 4: year start for the estimate and for one year earlier
	assign yoff4 = py_s3[33:26];
	assign ym4   = yoff4 - 8'd1;
	assign hour4 = py_s3[0] ? ph_s3[33:29] : ph_s3[33:29];
	always_ff @(posedge clk) begin
		if (adv) begin
			yoff_s4 <= yoff4;
			sa_s4   <= 17'(ym4 >> 2) + 17'(17'(yoff4) * 17'd365);
			sb_s4   <= 17'(8'(ym4 - 8'd1) >> 2) + 17'(17'(ym4) * 17'd365);
			dt_s4   <= dt_s3;
			hour_s4 <= hour4;
			r2_s4   <= 12'(rem_s3 - 17'(17'(hour4) * 17'(SECS_PER_HOUR)));
		end
	end

	// stage 5: correct year estimate, day of year, minute product
	assign lt5 = dt_s4 < sa_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			yoff_s5 <= lt5 ? yoff_s4 - 8'd1 : yoff_s4;
			doy_s5  <= 9'(dt_s4 - (lt5 ? sb_s4 : sa_s4));
			pm_s5   <= 25'(r2_s4) * 25'(RCP_60);
			r2_s5   <= r2_s4;
			hour_s5 <= hour_s4;
		end
	end

	// stage 6: month search over the cumulative table
	assign leap6 = (yoff_s5[1:0] == 2'd0);
	assign min6  = pm_s5[23:18];
	always_comb begin
		mon6 = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (doy_s5 >= cum_days(4'(i), leap6))
				mon6 = 4'(i);
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			year   <= 12'(yoff_s5) + BASE_YEAR;
			month  <= mon6 + 4'd1;
			day    <= 5'(doy_s5 - cum_days(mon6, leap6) + 9'd1);
			hour   <= hour_s5;
			minute <= min6;
			sec    <= 6'(r2_s5 - 12'(12'(min6) * 12'd60));
		end
	end

endmodule

/* rtl/escc_wday.sv */
// ----------------------------------------------------------------------------
// escc_wday
// Four-stage day-of-week from a decoded date; time fields ride along.
// ----------------------------------------------------------------------------
module escc_wday (
	input  logic        clk,
	input  logic        adv,
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  sec,
	output logic [11:0] out_year,
	output logic [3:0]  out_month,
	output logic [4:0]  out_day,
	output logic [4:0]  out_hour,
	output logic [5:0]  out_minute,
	output logic [5:0]  out_sec,
	output logic [2:0]  out_weekday
);
	import escc_pkg::*;

	logic [11:0] yr_s7, yr_s8, yr_s9;
	logic [3:0]  mo_s7, mo_s8, mo_s9;
	logic [4:0]  dy_s7, dy_s8, dy_s9;
	logic [4:0]  hr_s7, hr_s8, hr_s9;
	logic [5:0]  mn_s7, mn_s8, mn_s9;
	logic [5:0]  sc_s7, sc_s8, sc_s9;
	logic [11:0] y_s7;
	logic [9:0]  y4_s7;
	logic [20:0] p100_s7;
	logic [18:0] p400_s7;
	logic [4:0]  mt_s7;
	logic [13:0] t_s8, t_s9;
	logic [28:0] pt_s9;

	logic [11:0] y7;
	logic [4:0]  mt7;

	// (31 * m) / 12 with m the March-based month number
	always_comb begin
		unique case (month)
			4'd1:    mt7 = 5'd28;
			4'd2:    mt7 = 5'd31;
			4'd3:    mt7 = 5'd2;
			4'd4:    mt7 = 5'd5;
			4'd5:    mt7 = 5'd7;
			4'd6:    mt7 = 5'd10;
			4'd7:    mt7 = 5'd12;
			4'd8:    mt7 = 5'd15;
			4'd9:    mt7 = 5'd18;
			4'd10:   mt7 = 5'd20;
			4'd11:   mt7 = 5'd23;
			4'd12:   mt7 = 5'd25;
			default: mt7 = 5'd0;
		endcase
	end

	// stage 7: shifted year and century products
	assign y7 = (month <= 4'd2) ? year - 12'd1 : year;
	always_ff @(posedge clk) begin
		if (adv) begin
			y_s7    <= y7;
			y4_s7   <= y7[11:2];
			p100_s7 <= 21'(y7[11:2]) * 21'(RCP_25);
			p400_s7 <= 19'(y7[11:4]) * 19'(RCP_25);
			mt_s7   <= mt7;
			yr_s7 <= year;  mo_s7 <= month; dy_s7 <= day;
			hr_s7 <= hour;  mn_s7 <= minute; sc_s7 <= sec;
		end
	end

	// stage 8: weekday sum
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s8 <= WD_BIAS + 14'(dy_s7) + 14'(y_s7) + 14'(y4_s7)
			      - 14'(p100_s7[20:15]) + 14'(p400_s7[18:15]) + 14'(mt_s7);
			yr_s8 <= yr_s7; mo_s8 <= mo_s7; dy_s8 <= dy_s7;
			hr_s8 <= hr_s7; mn_s8 <= mn_s7; sc_s8 <= sc_s7;
		end
	end

	// stage 9: reciprocal product for mod 7
	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s9 <= 29'(t_s8) * 29'(RCP_7);
			t_s9  <= t_s8;
			yr_s9 <= yr_s8; mo_s9 <= mo_s8; dy_s9 <= dy_s8;
			hr_s9 <= hr_s8; mn_s9 <= mn_s8; sc_s9 <= sc_s8;
		end
	end

	// stage 10: remainder
	always_ff @(posedge clk) begin
		if (adv) begin
			out_weekday <= 3'(t_s9 - 14'(14'(pt_s9[27:17]) * 14'd7));
			out_year <= yr_s9; out_month <= mo_s9; out_day <= dy_s9;
			out_hour <= hr_s9; out_minute <= mn_s9; out_sec <= sc_s9;
		end
	end

endmodule

/* rtl/escc_enc.sv */
// ----------------------------------------------------------------------------
// escc_enc
// Four-stage encode of a calendar date and time into epoch seconds mod 2^32.
// ----------------------------------------------------------------------------
module escc_enc (
	input  logic        clk,
	input  logic        adv,
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  sec,
	output logic [31:0] secs
);
	import escc_pkg::*;

	logic signed [20:0] d1_s1, y365_s1, days_s2;
	logic        [16:0] hms_s1, hms_s2, hms_s3;
	logic        [31:0] prod_s3;

	logic signed [12:0] yoff1, ld1;
	logic               leap1;
	logic        [3:0]  mi1;
	logic signed [37:0] pr3;

	// year offset from 1900, floor leap count, clamped month index
	assign yoff1 = $signed({1'b0, year}) - $signed({1'b0, BASE_YEAR});
	assign ld1   = (yoff1 - 13'sd1) >>> 2;
	assign leap1 = (yoff1[1:0] == 2'd0) && (yoff1 != 13'sd0);
	always_comb begin
		priority if (month == 4'd0) mi1 = 4'd0;
		else if (month > 4'd12)     mi1 = 4'd11;
		else                        mi1 = month - 4'd1;
	end

	// stage 1: day-count terms and time of day
	always_ff @(posedge clk) begin
		if (adv) begin
			d1_s1   <= 21'(ld1) + $signed({12'd0, cum_days(mi1, leap1)})
			         + $signed({16'd0, day}) - 21'sd1 - $signed({4'd0, EPOCH_DAYS});
			y365_s1 <= 21'(yoff1) * 21'sd365;
			hms_s1  <= 17'(17'(hour) * 17'(SECS_PER_HOUR)) + 17'(17'(minute) * 17'd60)
			         + 17'(sec);
		end
	end

	// stage 2: days since epoch
	always_ff @(posedge clk) begin
		if (adv) begin
			days_s2 <= d1_s1 + y365_s1;
			hms_s2  <= hms_s1;
		end
	end

	// stage 3: days times 86400, low word
	assign pr3 = 38'(days_s2) * $signed({21'd0, SECS_PER_DAY});
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= pr3[31:0];
			hms_s3  <= hms_s2;
		end
	end

	// stage 4: final sum
	always_ff @(posedge clk) begin
		if (adv)
			secs <= prod_s3 + 32'(hms_s3);
	end

endmodule

/* rtl/epoch_seconds_calendar_converter.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_calendar_converter
// Converts epoch seconds to calendar date and time, or back, per transfer.
// ----------------------------------------------------------------------------
// channel  dir  payload
// s_*      in   tuser: op; tdata: seconds, year, month, day, hour, minute, sec
// m_*      out  tdata: seconds, year, month, day, hour, minute, sec, weekday
//
// Ten-stage pipeline: a transfer enters every cycle while the output is not
// stalled; the result reaches m_* through the ten register stages.
// Depth is set by the decode chain (day/year/month split, then weekday).
// Reset clears only the stage valid bits.
// A stalled output freezes all stages together; s_tready follows it.
// ----------------------------------------------------------------------------
module epoch_seconds_calendar_converter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [31:0] in_seconds, [43:32] in_year, [47:44] in_month, [52:48] in_day,
	// [57:53] in_hour, [63:58] in_minute, [69:64] in_sec
	input  logic [escc_pkg::IN_DATA_W-1:0]      s_tdata,
	// [0] op
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [31:0] out_seconds, [43:32] out_year, [47:44] out_month, [52:48] out_day,
	// [57:53] out_hour, [63:58] out_minute, [69:64] out_sec, [72:70] out_weekday
	output logic [escc_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import escc_pkg::*;

	localparam int unsigned DEPTH = 10;

	logic             adv;
	logic [DEPTH-1:0] vld_q;
	logic [DEPTH-1:0] op_q;
	logic [31:0]      enc_secs;
	logic [31:0]      esec_q [6];

	logic [11:0] d_year;
	logic [3:0]  d_month;
	logic [4:0]  d_day, d_hour;
	logic [5:0]  d_minute, d_sec;
	logic [11:0] w_year;
	logic [3:0]  w_month;
	logic [4:0]  w_day, w_hour;
	logic [5:0]  w_minute, w_sec;
	logic [2:0]  w_weekday;

	// whole pipeline moves when the output is free
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[DEPTH-1];

	// valid and op travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			op_q <= {op_q[DEPTH-2:0], s_tuser};
	end

	escc_dec u_dec (
		.clk    (clk),
		.adv    (adv),
		.secs   (s_tdata[31:0]),
		.year   (d_year),
		.month  (d_month),
		.day    (d_day),
		.hour   (d_hour),
		.minute (d_minute),
		.sec    (d_sec)
	);

	escc_wday u_wday (
		.clk         (clk),
		.adv         (adv),
		.year        (d_year),
		.month       (d_month),
		.day         (d_day),
		.hour        (d_hour),
		.minute      (d_minute),
		.sec         (d_sec),
		.out_year    (w_year),
		.out_month   (w_month),
		.out_day     (w_day),
		.out_hour    (w_hour),
		.out_minute  (w_minute),
		.out_sec     (w_sec),
		.out_weekday (w_weekday)
	);

	escc_enc u_enc (
		.clk    (clk),
		.adv    (adv),
		.year   (s_tdata[43:32]),
		.month  (s_tdata[47:44]),
		.day    (s_tdata[52:48]),
		.hour   (s_tdata[57:53]),
		.minute (s_tdata[63:58]),
		.sec    (s_tdata[69:64]),
		.secs   (enc_secs)
	);

	// align the encode result with the decode path
	always_ff @(posedge clk) begin
		if (adv) begin
			esec_q[0] <= enc_secs;
			for (int i = 1; i < 6; i++)
				esec_q[i] <= esec_q[i-1];
		end
	end

	// result select; unused fields are zero
	always_comb begin
		if (op_q[DEPTH-1] == OP_ENCODE) begin
			m_tdata = {48'd0, esec_q[5]};
		end else begin
			m_tdata = {7'd0, w_weekday, w_sec, w_minute, w_hour, w_day, w_month,
			           w_year, 32'd0};
		end
	end

endmodule

/* tb/sv/tb_epoch_seconds_calendar_converter.sv */
// ----------------------------------------------------------------------------
// tb_epoch_seconds_calendar_converter
// Self-checking bench for the epoch seconds / calendar converter. A directed
// table covers the field extremes and corner dates. Random decode and encode
// transfers follow under random idling on both sides, a long output stall
// and a drain pause. Results are checked against a calendar predictor or typed-in values.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_calendar_converter;
	timeunit 1ns;
	timeprecision 1ps;
	import escc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct {
		logic [31:0] secs;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  sec;
		logic [2:0]  wday;
	} cal_t;

	// one row of the directed table; known rows carry their result typed in
	typedef struct {
		logic op;
		cal_t arg;
		bit   known;
		cal_t res;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	cal_t        cal_expected[$];
	int unsigned errors;
	int unsigned cycles;
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned rx_hold_len;

	epoch_seconds_calendar_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// days before the first of each month
	function automatic int unsigned month_start(int unsigned mi, bit leap);
		int unsigned common[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
		return common[mi] + ((leap && mi >= 2) ? 1 : 0);
	endfunction

	// Gregorian day of week, 0 Sunday
	function automatic int unsigned day_of_week(int unsigned d, int unsigned m, int unsigned y);
		int unsigned a;
		int unsigned yy;
		int unsigned mm;
		a  = (14 - m) / 12;
		yy = y - a;
		mm = m + 12 * a - 2;
		return (7000 + d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
	endfunction

	function automatic cal_t seconds_to_calendar(logic [31:0] s);
		cal_t        r;
		longint      total;
		int unsigned days;
		int unsigned rem;
		int unsigned yoff;
		int unsigned mon;
		bit          leap;
		total = longint'(s) + 64'd25567 * 64'd86400;
		days  = 32'(total / 86400);
		rem   = 32'(total % 86400);
		yoff  = days / 365;
		while (yoff > 1 && days < (yoff - 1) / 4 + 365 * yoff)
			yoff--;
		days -= (yoff - 1) / 4 + 365 * yoff;
		leap = !((yoff & 3) != 0 || yoff == 0);
		mon  = 11;
		while (mon > 0 && days < month_start(mon, leap))
			mon--;
		r.secs   = '0;
		r.year   = 12'(yoff + 1900);
		r.month  = 4'(mon + 1);
		r.day    = 5'(days - month_start(mon, leap) + 1);
		r.hour   = 5'(rem / 3600);
		r.minute = 6'((rem % 3600) / 60);
		r.sec    = 6'(rem % 60);
		r.wday   = 3'(day_of_week(days - month_start(mon, leap) + 1, mon + 1, yoff + 1900));
		return r;
	endfunction

	function automatic cal_t calendar_to_seconds(cal_t c);
		cal_t        r;
		longint      yoff;
		longint      days;
		longint      secs;
		int unsigned mi;
		yoff = longint'(c.year) - 1900;
		mi   = (c.month == 0) ? 0 : (c.month > 12) ? 11 : c.month - 1;
		days = (yoff - 1 + 2000) / 4 - 500
			+ month_start(mi, !(yoff % 4 != 0 || yoff == 0)) - 1
			+ 365 * yoff + longint'(c.day) - 25567;
		secs = 3600 * longint'(c.hour) + 60 * longint'(c.minute) + longint'(c.sec)
			+ days * 86400;
		r      = '{default: '0};
		r.secs = secs[31:0];
		return r;
	endfunction

	function automatic cal_t convert(logic op, cal_t arg);
		return (op == OP_DECODE) ? seconds_to_calendar(arg.secs) : calendar_to_seconds(arg);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	// offer one transfer, wait for it to be taken, then maybe idle
	task automatic send_item(logic op, cal_t arg, bit known, cal_t res);
		logic [IN_DATA_W-1:0] d;
		d        = '0;
		d[31:0]  = arg.secs;
		d[43:32] = arg.year;
		d[47:44] = arg.month;
		d[52:48] = arg.day;
		d[57:53] = arg.hour;
		d[63:58] = arg.minute;
		d[69:64] = arg.sec;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		cal_expected.push_back(known ? res : convert(op, arg));
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic cal_t random_arg(output logic op);
		cal_t a;
		a    = '{default: '0};
		op   = 1'($urandom_range(1));
		a.secs = $urandom;
		if ($urandom_range(99) < 85) begin
			a.year   = 12'($urandom_range(2105, 1970));
			a.month  = 4'($urandom_range(12, 1));
			a.day    = 5'($urandom_range(31, 1));
			a.hour   = 5'($urandom_range(23));
			a.minute = 6'($urandom_range(59));
			a.sec    = 6'($urandom_range(59));
		end else begin
			a.year   = 12'($urandom);
			a.month  = 4'($urandom);
			a.day    = 5'($urandom);
			a.hour   = 5'($urandom);
			a.minute = 6'($urandom);
			a.sec    = 6'($urandom);
		end
		return a;
	endfunction

	task automatic send_random(int unsigned n);
		logic op;
		cal_t a;
		cal_t none;
		none = '{default: '0};
		repeat (n) begin
			a = random_arg(op);
			send_item(op, a, 1'b0, none);
		end
	endtask

	// receiver: random backpressure, or a long counted hold-off on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_len > 0) begin
				m_tready <= 1'b0;
				rx_hold_len--;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		cal_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (cal_expected.size() == 0) begin
				$display("unexpected result transfer (cycle %0d)", cycles);
				errors++;
			end else begin
				want = cal_expected.pop_front();
				if (m_tdata[31:0] !== want.secs)
					report_mismatch("seconds", m_tdata[31:0], want.secs);
				if (m_tdata[43:32] !== want.year)
					report_mismatch("year", m_tdata[43:32], want.year);
				if (m_tdata[47:44] !== want.month)
					report_mismatch("month", m_tdata[47:44], want.month);
				if (m_tdata[52:48] !== want.day)
					report_mismatch("day", m_tdata[52:48], want.day);
				if (m_tdata[57:53] !== want.hour)
					report_mismatch("hour", m_tdata[57:53], want.hour);
				if (m_tdata[63:58] !== want.minute)
					report_mismatch("minute", m_tdata[63:58], want.minute);
				if (m_tdata[69:64] !== want.sec)
					report_mismatch("sec", m_tdata[69:64], want.sec);
				if (m_tdata[72:70] !== want.wday)
					report_mismatch("weekday", m_tdata[72:70], want.wday);
			end
		end
	end

	// run limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout with %0d results outstanding", cal_expected.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		row_t rows[$];
		cal_t z;
		cal_t a;
		errors      = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_len = 0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = OP_DECODE;
		z           = '{default: '0};

		// decode: epoch start (Thursday) and the last count, which lands a day
		// early (Saturday) because 2100 counts as a leap year
		a = z; a.secs = 32'd0;
		rows.push_back('{OP_DECODE, a, 1'b1, '{32'd0, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd4}});
		a = z; a.secs = 32'hFFFF_FFFF;
		rows.push_back('{OP_DECODE, a, 1'b1,
			'{32'd0, 12'd2106, 4'd2, 5'd6, 5'd6, 6'd28, 6'd15, 3'd6}});
		// leap day 2000, first of March 2100, end of 1999
		a = z; a.secs = 32'd951782400; rows.push_back('{OP_DECODE, a, 1'b0, z});
		a = z; a.secs = 32'd4107542400; rows.push_back('{OP_DECODE, a, 1'b0, z});
		a = z; a.secs = 32'd946684799; rows.push_back('{OP_DECODE, a, 1'b0, z});
		a = z; a.secs = 32'h8000_0000; rows.push_back('{OP_DECODE, a, 1'b0, z});
		// encode: epoch start is zero, then range end and leap corner dates
		a = z; a.year = 12'd1970; a.month = 4'd1; a.day = 5'd1;
		rows.push_back('{OP_ENCODE, a, 1'b1, z});
		a = '{0, 2105, 12, 31, 23, 59, 59, 0}; rows.push_back('{OP_ENCODE, a, 1'b0, z});
		a = '{0, 2000, 2, 29, 12, 30, 30, 0}; rows.push_back('{OP_ENCODE, a, 1'b0, z});
		a = '{0, 2100, 3, 1, 0, 0, 0, 0}; rows.push_back('{OP_ENCODE, a, 1'b0, z});
		// month zero and months above twelve
		a = '{0, 1999, 0, 15, 1, 2, 3, 0}; rows.push_back('{OP_ENCODE, a, 1'b0, z});
		a = '{0, 1999, 15, 15, 1, 2, 3, 0}; rows.push_back('{OP_ENCODE, a, 1'b0, z});
		a = '{0, 1999, 13, 15, 1, 2, 3, 0}; rows.push_back('{OP_ENCODE, a, 1'b0, z});
		// day zero and unchecked time fields at full width
		a = '{0, 1980, 3, 0, 0, 0, 0, 0}; rows.push_back('{OP_ENCODE, a, 1'b0, z});
		a = '{0, 1980, 2, 31, 31, 63, 63, 0}; rows.push_back('{OP_ENCODE, a, 1'b0, z});
		// years before 1970, 1900 itself, 1904 leap day, full-width year
		a = '{0, 0, 1, 1, 0, 0, 0, 0}; rows.push_back('{OP_ENCODE, a, 1'b0, z});
		a = '{0, 1900, 3, 1, 0, 0, 0, 0}; rows.push_back('{OP_ENCODE, a, 1'b0, z});
		a = '{0, 1904, 2, 29, 0, 0, 0, 0}; rows.push_back('{OP_ENCODE, a, 1'b0, z});
		a = '{0, 1969, 12, 31, 23, 59, 59, 0}; rows.push_back('{OP_ENCODE, a, 1'b0, z});
		a = '{0, 4095, 15, 31, 31, 63, 63, 0}; rows.push_back('{OP_ENCODE, a, 1'b0, z});
		a = '{0, 2106, 2, 7, 6, 28, 16, 0}; rows.push_back('{OP_ENCODE, a, 1'b0, z});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_item(rows[i].op, rows[i].arg, rows[i].known, rows[i].res);

		// sender idles rarely, receiver often, then the other way round
		tx_idle_pct = 26; rx_idle_pct = 73;
		send_random(180);
		tx_idle_pct = 73; rx_idle_pct = 26;
		send_random(180);

		// long output hold-off while transfers keep coming
		tx_idle_pct = 0; rx_idle_pct = 0;
		rx_hold_len = 300;
		send_random(40);

		// pause until everything has drained, then run flat out
		s_tvalid <= 1'b0;
		while (cal_expected.size() != 0) @(posedge clk);
		send_random(180);
		s_tvalid <= 1'b0;

		while (cal_expected.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
